FILE: src/bqd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bqd_pkg
// Types, constants and float helpers shared by the block dequantizer.
// ----------------------------------------------------------------------------
package bqd_pkg;

	localparam int unsigned QueueDepth = 2;

	typedef enum logic [2:0] {
		FMT_Q8_0 = 3'd0,
		FMT_Q4_0 = 3'd1,
		FMT_Q4_1 = 3'd2,
		FMT_Q5_0 = 3'd3,
		FMT_Q5_1 = 3'd4
	} fmt_t;

	localparam logic [31:0] QuietBit   = 32'h0040_0000;
	localparam logic [31:0] DefaultNan = 32'hFFC0_0000;
	localparam logic [31:0] ExpMask    = 32'h7F80_0000;

	// one queued work element: a single product (and optional add)
	typedef struct packed {
		logic [31:0] d;
		logic [31:0] m;
		logic        add_min;
		logic signed [8:0] q;
		logic [4:0]  elem;
		logic        last;
	} work_t;

	function automatic logic [31:0] half_to_single(input logic [15:0] h);
		logic [4:0]  ex;
		logic [9:0]  man;
		logic [3:0]  lz;
		logic [10:0] sh;
		logic [7:0]  e;
		ex  = h[14:10];
		man = h[9:0];
		lz  = 4'd0;
		for (int i = 9; i >= 0; i--) begin
			if (man[i] && lz == 4'd0 && (man >> (i + 1)) == 10'd0) lz = 4'(10 - i);
		end
		sh = {1'b0, man} << lz;
		e = 8'd113 - {4'd0, lz};
		if (ex == 5'd0) begin
			if (man == 10'd0) half_to_single = {h[15], 31'd0};
			else half_to_single = {h[15], e, sh[9:0], 13'd0};
		end else if (ex == 5'd31) begin
			half_to_single = {h[15], 8'hFF, man, 13'd0};
		end else begin
			half_to_single = {h[15], 8'(ex) + 8'd112, man, 13'd0};
		end
	endfunction

	function automatic logic is_nan(input logic [31:0] b);
		is_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
	endfunction

	function automatic logic is_inf(input logic [31:0] b);
		is_inf = (b[30:0] == ExpMask[30:0]);
	endfunction

endpackage
`default_nettype wire

FILE: src/bqd_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bqd_in_if / bqd_out_if / bqd_cfg_if
// Valid/ready channels of the block dequantizer.
// ----------------------------------------------------------------------------
interface bqd_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] scale_bits;
	logic [15:0] min_bits;
	logic [31:0] high_bits;
	logic [7:0]  quant_byte;
	logic [4:0]  byte_index;
	modport source (output valid, scale_bits, min_bits, high_bits, quant_byte, byte_index,
		input ready);
	modport sink (input valid, scale_bits, min_bits, high_bits, quant_byte, byte_index,
		output ready);
endinterface

interface bqd_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] value_bits;
	logic [4:0]  element_index;
	logic        last;
	modport source (output valid, value_bits, element_index, last, input ready);
	modport sink (input valid, value_bits, element_index, last, output ready);
endinterface

interface bqd_cfg_if;
	logic       valid;
	logic       ready;
	logic [2:0] format;
	modport source (output valid, format, input ready);
	modport sink (input valid, format, output ready);
endinterface
`default_nettype wire

FILE: src/bqd_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bqd_front
// Accepts quant bytes, decodes format, splits nibbles into work elements.
// ----------------------------------------------------------------------------
module bqd_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic [2:0]    format,
	bqd_in_if.sink             in_ch,
	output bqd_pkg::work_t     wk,
	output logic               wk_valid,
	input  wire logic          wk_ready
);
	logic        pend_q;
	logic        second_q;
	logic [31:0] d_q, m_q;
	logic [31:0] hb_q;
	logic [7:0]  qb_q;
	logic [4:0]  idx_q;
	logic [2:0]  fmt_q;
	logic [3:0]  j;
	logic [4:0]  nib;
	logic        fin;

	assign j = idx_q[3:0];
	assign fin = wk_valid && wk_ready && (fmt_q == bqd_pkg::FMT_Q8_0 || second_q);
	assign in_ch.ready = !pend_q || fin;
	assign wk_valid = pend_q;

	always_comb begin
		nib = second_q ? {hb_q[{1'b1, j}], qb_q[7:4]} : {hb_q[{1'b0, j}], qb_q[3:0]};
		wk.d = d_q;
		wk.m = m_q;
		wk.add_min = 1'b0;
		wk.elem = second_q ? {1'b1, j} : {1'b0, j};
		wk.last = second_q;
		wk.q = '0;
		case (fmt_q)
			bqd_pkg::FMT_Q8_0: begin
				wk.q = {qb_q[7], qb_q};
				wk.elem = idx_q;
				wk.last = 1'b1;
			end
			bqd_pkg::FMT_Q4_0: wk.q = 9'({5'd0, nib[3:0]}) - 9'sd8;
			bqd_pkg::FMT_Q4_1: begin
				wk.q = {5'd0, nib[3:0]};
				wk.add_min = 1'b1;
			end
			bqd_pkg::FMT_Q5_0: wk.q = 9'({4'd0, nib}) - 9'sd16;
			bqd_pkg::FMT_Q5_1: begin
				wk.q = {4'd0, nib};
				wk.add_min = 1'b1;
			end
			default: wk.q = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
			second_q <= 1'b0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				// undefined formats produce nothing
				pend_q <= (format <= 3'(bqd_pkg::FMT_Q5_1));
				second_q <= 1'b0;
			end else if (fin) begin
				pend_q <= 1'b0;
			end else if (wk_valid && wk_ready) begin
				second_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			d_q   <= bqd_pkg::half_to_single(in_ch.scale_bits);
			m_q   <= bqd_pkg::half_to_single(in_ch.min_bits);
			hb_q  <= in_ch.high_bits;
			qb_q  <= in_ch.quant_byte;
			idx_q <= in_ch.byte_index;
			fmt_q <= format;
		end
	end
endmodule
`default_nettype wire

FILE: src/bqd_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bqd_queue
// Short FIFO of work elements between front and back.
// ----------------------------------------------------------------------------
module bqd_queue #(
	parameter int unsigned Depth = bqd_pkg::QueueDepth
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire bqd_pkg::work_t wr_data,
	input  wire logic          wr_valid,
	output logic               wr_ready,
	output bqd_pkg::work_t     rd_data,
	output logic               rd_valid,
	input  wire logic          rd_ready
);
	localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
	bqd_pkg::work_t mem_q [Depth];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0]   cnt_q;
	logic wr, rd;

	assign wr_ready = cnt_q != (AW+1)'(Depth);
	assign rd_valid = cnt_q != '0;
	assign rd_data = mem_q[rp_q];
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= (wp_q == AW'(Depth - 1)) ? '0 : wp_q + 1'b1;
			if (rd) rp_q <= (rp_q == AW'(Depth - 1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(wr) - (AW+1)'(rd);
		end
	end

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_data;
	end
endmodule
`default_nettype wire

FILE: src/bqd_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bqd_back
// Truncated (not rounded) scale product, then optional rounded add of the minimum.
// ----------------------------------------------------------------------------
module bqd_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire bqd_pkg::work_t wk,
	input  wire logic           wk_valid,
	output logic                wk_ready,
	bqd_out_if.source           out_ch
);
	// stage 1: product
	logic        v_s1;
	logic [31:0] p_s1, m_s1;
	logic        add_s1;
	logic [4:0]  elem_s1;
	logic        last_s1;
	logic        adv1, adv2;

	logic [31:0] prod;
	logic [8:0]  aq;
	logic [32:0] mw;
	logic [5:0]  lz;
	logic [32:0] mn;
	logic [9:0]  ex;
	logic [23:0] dm;
	logic [7:0]  de;
	always_comb begin
		aq = wk.q[8] ? 9'(-wk.q) : 9'(wk.q);
		de = wk.d[30:23];
		dm = (de == 8'd0) ? {1'b0, wk.d[22:0]} : {1'b1, wk.d[22:0]};
		mw = {9'd0, dm} * {24'd0, aq};
		lz = 6'd0;
		for (int i = 32; i >= 0; i--) begin
			if (mw[i] && lz == 6'd0 && (mw >> (i + 1)) == 33'd0) lz = 6'(32 - i);
		end
		mn = mw << lz;
		// value = mw * 2^(E-150), E=max(de,1); normalized hidden bit at mn[32]
		ex = 10'({2'd0, (de == 8'd0) ? 8'd1 : de}) + 10'd9 - 10'(lz);
		if (bqd_pkg::is_nan(wk.d)) prod = wk.d | bqd_pkg::QuietBit;
		else if (bqd_pkg::is_inf(wk.d))
			prod = (aq == 9'd0) ? bqd_pkg::DefaultNan : {wk.d[31] ^ wk.q[8], 31'h7F80_0000};
		else if (mw == 33'd0) prod = {wk.d[31] ^ wk.q[8], 31'd0};
		else if (ex[9] || ex == 10'd0)
			prod = {wk.d[31] ^ wk.q[8], 8'd0, 23'(mn[32:9] >> (10'd1 - ex))};
		else prod = {wk.d[31] ^ wk.q[8], ex[7:0], mn[31:9]};
	end

	// stage 2: add with round to nearest even
	logic        v_s2;
	logic [31:0] r_s2;
	logic [4:0]  elem_s2;
	logic        last_s2;

	logic [31:0] sum, big, sml;
	logic [7:0]  eb, es;
	logic [26:0] fb, fs, fss;
	logic [27:0] acc;
	logic [7:0]  sd;
	logic        sticky, sub;
	logic [4:0]  nz;
	logic [27:0] an;
	logic [9:0]  re;
	logic [23:0] rm;
	logic [24:0] rr;
	logic        rb, st, lsb;
	logic [31:0] r_s2_n;
	always_comb begin
		if ({1'b0, p_s1[30:0]} >= {1'b0, m_s1[30:0]}) begin
			big = p_s1; sml = m_s1;
		end else begin
			big = m_s1; sml = p_s1;
		end
		eb = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
		es = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
		fb = {(big[30:23] != 8'd0), big[22:0], 3'd0};
		fs = {(sml[30:23] != 8'd0), sml[22:0], 3'd0};
		sd = eb - es;
		if (sd > 8'd26) begin
			fss = '0;
			sticky = fs != '0;
		end else begin
			fss = fs >> sd;
			sticky = (fs & ~(27'h7FF_FFFF << sd)) != '0;
		end
		fss[0] = fss[0] | sticky;
		sub = big[31] ^ sml[31];
		acc = sub ? {1'b0, fb} - {1'b0, fss} : {1'b0, fb} + {1'b0, fss};
		nz = 5'd0;
		for (int i = 27; i >= 0; i--) begin
			if (acc[i] && nz == 5'd0 && (acc >> (i + 1)) == 28'd0) nz = 5'(27 - i);
		end
		// leading one goes to bit 27; exponent of bit 26 is eb
		re = {2'd0, eb} + 10'd1 - 10'(nz);
		if (re[9] || re == 10'd0) begin
			an = acc << (10'(nz) + re - 10'd1);
			re = 10'd0;
		end else an = acc << nz;
		rm = an[27:4];
		rb = an[3];
		st = an[2:0] != 3'd0;
		lsb = an[4];
		rr = {1'b0, rm} + 25'(rb && (st || lsb));
		if (rr[24]) begin
			re = re + 10'd1;
			rr = rr >> 1;
		end else if (re == 10'd0 && rr[23]) re = 10'd1;
		if (acc == 28'd0) sum = {big[31] & sml[31], 31'd0};
		else if (re >= 10'd255) sum = {big[31], 31'h7F80_0000};
		else sum = {big[31], re[7:0], rr[22:0]};

		if (!add_s1 || bqd_pkg::is_nan(p_s1)) r_s2_n = p_s1;
		else if (bqd_pkg::is_nan(m_s1)) r_s2_n = m_s1 | bqd_pkg::QuietBit;
		else if (bqd_pkg::is_inf(p_s1) && bqd_pkg::is_inf(m_s1))
			r_s2_n = (p_s1[31] != m_s1[31]) ? bqd_pkg::DefaultNan : p_s1;
		else if (bqd_pkg::is_inf(p_s1)) r_s2_n = p_s1;
		else if (bqd_pkg::is_inf(m_s1)) r_s2_n = m_s1;
		else r_s2_n = sum;
	end

	assign adv2 = !v_s2 || out_ch.ready;
	assign adv1 = !v_s1 || adv2;
	assign wk_ready = adv1;
	assign out_ch.valid = v_s2;
	assign out_ch.value_bits = r_s2;
	assign out_ch.element_index = elem_s2;
	assign out_ch.last = last_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= wk_valid;
			if (adv2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && wk_valid) begin
			p_s1 <= prod;
			m_s1 <= wk.m;
			add_s1 <= wk.add_min;
			elem_s1 <= wk.elem;
			last_s1 <= wk.last;
		end
		if (adv2 && v_s1) begin
			r_s2 <= r_s2_n;
			elem_s2 <= elem_s1;
			last_s2 <= last_s1;
		end
	end

`ifndef SYNTHESIS
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(r_s2))
		else $error("result changed while stalled");
	a_s2: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && adv2 |=> v_s2)
		else $error("stage 1 item lost");
	a_rdy: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 |-> wk_ready)
		else $error("back stalled while empty");
`endif
endmodule
`default_nettype wire

FILE: src/block_quant_dequantizer.sv
`default_nettype none
// Data path: front reg, queue, two stages between input transfer and result.
// Throughput: one result per cycle while out_ch.ready holds; a Q8_0 byte gives one
// element, a nibble-format byte two; the single product/add unit emits one per cycle.
// Reset (arst_n low) empties all stages and sets format to Q8_0.
// ----------------------------------------------------------------------------
// block_quant_dequantizer
// Legacy 32-element block dequantizer to fp32, front/queue/back structure.
// ----------------------------------------------------------------------------
module block_quant_dequantizer #(
	parameter int unsigned QueueDepth = bqd_pkg::QueueDepth
) (
	input  wire logic clk,
	input  wire logic arst_n,
	bqd_cfg_if.sink   cfg,
	bqd_in_if.sink    in_ch,
	bqd_out_if.source out_ch
);
	logic [2:0]     format_q;
	bqd_pkg::work_t f_wk, q_wk;
	logic f_v, f_r, q_v, q_r;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) format_q <= 3'(bqd_pkg::FMT_Q8_0);
		else if (cfg.valid) format_q <= cfg.format;
	end

	bqd_front u_front (.clk, .arst_n, .format(format_q), .in_ch,
		.wk(f_wk), .wk_valid(f_v), .wk_ready(f_r));
	bqd_queue #(.Depth(QueueDepth)) u_queue (.clk, .arst_n, .wr_data(f_wk), .wr_valid(f_v),
		.wr_ready(f_r), .rd_data(q_wk), .rd_valid(q_v), .rd_ready(q_r));
	bqd_back u_back (.clk, .arst_n, .wk(q_wk), .wk_valid(q_v), .wk_ready(q_r), .out_ch);
endmodule
`default_nettype wire
